// ===== src/ogpd_pkg.sv =====
// shared types and constants of the ogg page deframer
package ogpd_pkg;

	// parser phase
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_TABLE  = 2'd1,
		PH_BODY   = 2'd2
	} phase_t;

	localparam int unsigned HDR_LEN = 27;
	localparam int unsigned CAPTURE_LEN = 4;
	localparam logic [4:0] HDR_CAPTURE_END = 5'(CAPTURE_LEN);
	localparam logic [4:0] HDR_FLAGS_POS = 5'd5;
	localparam logic [4:0] HDR_LAST_POS = 5'(HDR_LEN - 1);
	localparam logic [7:0] FULL_SEG = 8'd255;
	localparam logic [7:0] CAPTURE_O = 8'h4F;
	localparam logic [7:0] CAPTURE_G = 8'h67;
	localparam logic [7:0] CAPTURE_S = 8'h53;

	// one stored segment: a non-zero length and the zero-length segments behind it
	typedef struct packed {
		logic [7:0] len;
		logic [7:0] zeros;
	} seg_entry_t;

	localparam int unsigned ENTRY_W = $bits(seg_entry_t);

	// one result beat
	typedef struct packed {
		logic       data_valid;
		logic [7:0] data_byte;
		logic [7:0] packet_ends;
		logic       page_end;
		logic       page_continued;
		logic       capture_error;
	} result_t;

	// expected capture pattern byte at a header position
	function automatic logic [7:0] capture_byte(input logic [1:0] pos);
		logic [7:0] b;
		unique case (pos)
			2'd0: b = CAPTURE_O;
			2'd1: b = CAPTURE_G;
			2'd2: b = CAPTURE_G;
			default: b = CAPTURE_S;
		endcase
		return b;
	endfunction

endpackage

// ===== src/ogpd_ram.sv =====
// generic single write port, single read port ram with registered read
module ogpd_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 255
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== src/ogg_page_packet_deframer_unit.sv =====
// ogg page deframer top level: header check, segment table store, body pass-through
//
// usage
// - input channel: one stream byte per beat on byte_in, in_valid / in_stall
// - output channel: one result beat per body byte, and one per header or table
//   byte that raises a capture error, closes a page or closes packets
// - a result leaves in the cycle after its byte is taken, from an output register
// - throughput is one byte per cycle while out_stall does not hold the output: each
//   segment needs a single read of the segment ram, issued as the previous
//   segment's last byte is taken, so no byte waits on the ram's registered read
// - zero-length segments are folded into the preceding non-zero entry while the
//   table loads (leading ones into a counter), so their endings come out on the
//   same beat as the byte before them
// - when the output register holds a beat and out_stall is high, in_stall rises
//   and no byte is taken until the beat leaves
// - after reset the parser hunts for a capture pattern; the ram needs no clearing
//   pass, every entry is written before a body byte reads it
module ogg_page_packet_deframer_unit #(
	parameter int unsigned MAX_SEGMENTS = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       data_valid,
	output logic [7:0] data_byte,
	output logic [7:0] packet_ends,
	output logic       page_end,
	output logic       page_continued,
	output logic       capture_error
);
	import ogpd_pkg::*;

	// ram address width and a count wide enough to hold MAX_SEGMENTS itself
	localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [7:0] SEG_LIMIT = 8'(MAX_SEGMENTS);

	// parser state
	phase_t        phase_q, phase_d;
	logic [4:0]    hp_q, hp_d;           // header byte position
	logic [7:0]    seg_cnt_q, seg_cnt_d; // segments on this page, saturated
	logic [7:0]    seg_idx_q, seg_idx_d; // table byte being loaded
	logic [7:0]    lead_q, lead_d;       // zero-length segments ahead of the first real one
	logic [7:0]    zrun_q, zrun_d;       // zeros behind the last non-zero segment
	logic [7:0]    prev_len_q, prev_len_d;
	logic [CW-1:0] nz_q, nz_d;           // non-zero segments stored
	logic [AW-1:0] cur_q, cur_d;         // entry being passed through
	logic [7:0]    rem_q, rem_d;         // body bytes left in this segment
	logic          first_q, first_d;     // segment length still only at the ram output
	logic          cont_q, cont_d;

	// bypass for an entry written in the cycle it is first read
	logic          fwd_sel_q, fwd_sel_d;
	seg_entry_t    fwd_q, fwd_d;

	// ram ports
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	seg_entry_t        ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	// output register
	logic    out_valid_q;
	result_t res_q;
	result_t res;
	logic    emit;
	logic    accept;

	// body scratch
	seg_entry_t    entry;
	logic [7:0]    rem_cur;
	logic [7:0]    rem_dec;
	logic [CW-1:0] nz_minus;
	logic          last_seg;

	ogpd_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_SEGMENTS)
	) u_seg_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign entry    = fwd_sel_q ? fwd_q : seg_entry_t'(ram_rdata);
	assign rem_cur  = first_q ? entry.len : rem_q;
	assign rem_dec  = rem_cur - 8'd1;
	assign nz_minus = nz_q - CW'(1);
	assign last_seg = (CW'(cur_q) == nz_minus);

	always_comb begin
		phase_d    = phase_q;
		hp_d       = hp_q;
		seg_cnt_d  = seg_cnt_q;
		seg_idx_d  = seg_idx_q;
		lead_d     = lead_q;
		zrun_d     = zrun_q;
		prev_len_d = prev_len_q;
		nz_d       = nz_q;
		cur_d      = cur_q;
		rem_d      = rem_q;
		first_d    = first_q;
		cont_d     = cont_q;
		fwd_sel_d  = fwd_sel_q;
		fwd_d      = fwd_q;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = '0;
		ram_re     = 1'b0;
		ram_raddr  = '0;
		emit       = 1'b0;
		res        = '0;

		if (accept) begin
			unique case (phase_q)
				PH_TABLE: begin
					if (byte_in != 8'd0) begin
						// new non-zero segment opens an entry
						ram_we     = 1'b1;
						ram_waddr  = nz_q[AW-1:0];
						ram_wdata  = '{len: byte_in, zeros: 8'd0};
						prev_len_d = byte_in;
						zrun_d     = 8'd0;
						nz_d       = nz_q + CW'(1);
					end else if (nz_q == '0) begin
						lead_d = lead_q + 8'd1;
					end else begin
						// fold the zero into the entry before it
						ram_we    = 1'b1;
						ram_waddr = nz_minus[AW-1:0];
						ram_wdata = '{len: prev_len_q, zeros: zrun_q + 8'd1};
						zrun_d    = zrun_q + 8'd1;
					end
					seg_idx_d = seg_idx_q + 8'd1;
					if (seg_idx_d == seg_cnt_q) begin
						if (nz_d == '0) begin
							// only empty packets on this page
							emit             = 1'b1;
							res.packet_ends  = lead_d;
							res.page_end     = 1'b1;
							phase_d          = PH_HEADER;
							hp_d             = '0;
						end else begin
							emit            = (lead_d != 8'd0);
							res.packet_ends = lead_d;
							phase_d         = PH_BODY;
							cur_d           = '0;
							first_d         = 1'b1;
							ram_re          = 1'b1;
							ram_raddr       = '0;
							fwd_sel_d       = ram_we && (ram_waddr == '0);
							fwd_d           = ram_wdata;
						end
					end
				end
				PH_BODY: begin
					emit           = 1'b1;
					res.data_valid = 1'b1;
					res.data_byte  = byte_in;
					first_d        = 1'b0;
					rem_d          = rem_dec;
					if (rem_dec == 8'd0) begin
						// segment done: short segment ends a packet, folded zeros
						// end one each, an open packet is closed at page end
						res.packet_ends = {7'd0, entry.len != FULL_SEG} + entry.zeros
							+ {7'd0, last_seg && (entry.len == FULL_SEG)
								&& (entry.zeros == 8'd0)};
						if (last_seg) begin
							res.page_end = 1'b1;
							phase_d      = PH_HEADER;
							hp_d         = '0;
						end else begin
							cur_d     = cur_q + AW'(1);
							ram_re    = 1'b1;
							ram_raddr = cur_q + AW'(1);
							first_d   = 1'b1;
							fwd_sel_d = 1'b0;
						end
					end
				end
				default: begin
					// header phase, also taken for the unused phase code
					phase_d = PH_HEADER;
					if (hp_q < HDR_CAPTURE_END) begin
						if (byte_in != capture_byte(hp_q[1:0])) begin
							// resync, an 'O' may already start the next pattern
							hp_d              = (byte_in == CAPTURE_O) ? 5'd1 : 5'd0;
							emit              = 1'b1;
							res.capture_error = 1'b1;
						end else begin
							hp_d = hp_q + 5'd1;
						end
					end else if (hp_q == HDR_LAST_POS) begin
						seg_cnt_d = (byte_in > SEG_LIMIT) ? SEG_LIMIT : byte_in;
						hp_d      = '0;
						seg_idx_d = 8'd0;
						nz_d      = '0;
						lead_d    = 8'd0;
						zrun_d    = 8'd0;
						if (seg_cnt_d == 8'd0) begin
							emit         = 1'b1;
							res.page_end = 1'b1;
						end else begin
							phase_d = PH_TABLE;
						end
					end else begin
						if (hp_q == HDR_FLAGS_POS) begin
							cont_d = byte_in[0];
						end
						hp_d = hp_q + 5'd1;
					end
				end
			endcase
		end
		res.page_continued = cont_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hp_q        <= '0;
			seg_cnt_q   <= '0;
			seg_idx_q   <= '0;
			lead_q      <= '0;
			zrun_q      <= '0;
			nz_q        <= '0;
			cur_q       <= '0;
			rem_q       <= '0;
			first_q     <= 1'b0;
			cont_q      <= 1'b0;
			fwd_sel_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			hp_q      <= hp_d;
			seg_cnt_q <= seg_cnt_d;
			seg_idx_q <= seg_idx_d;
			lead_q    <= lead_d;
			zrun_q    <= zrun_d;
			nz_q      <= nz_d;
			cur_q     <= cur_d;
			rem_q     <= rem_d;
			first_q   <= first_d;
			cont_q    <= cont_d;
			fwd_sel_q <= fwd_sel_d;
			if (accept && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		prev_len_q <= prev_len_d;
		fwd_q      <= fwd_d;
		if (accept && emit) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign data_valid     = res_q.data_valid;
	assign data_byte      = res_q.data_byte;
	assign packet_ends    = res_q.packet_ends;
	assign page_end       = res_q.page_end;
	assign page_continued = res_q.page_continued;
	assign capture_error  = res_q.capture_error;

	// body is only entered with at least one stored entry, and stays within them
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> (nz_q != '0) && (CW'(cur_q) < nz_q))
		else $error("body entry index outside stored segments");

	// table loading never runs past the segment count
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TABLE |-> seg_idx_q < seg_cnt_q)
		else $error("table index beyond segment count");

	// a capture error beat carries no body byte, page end or packet endings
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && capture_error |-> !data_valid && !page_end && (packet_ends == 8'd0))
		else $error("capture error beat with body or ending fields");

	// a body byte that closes a page always closes at least one packet
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_valid && page_end |-> packet_ends != 8'd0)
		else $error("page closed on body byte without packet ending");
endmodule
